// ===== hw/rtl/pdeq_pkg.sv =====
// ============================================================================
// pdeq_pkg
// Shared types and constants of the paced duplicate-filtering event queue.
// ============================================================================
package pdeq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int OP_W            = 2;
    localparam int ID_W            = 12;
    localparam int PAYLOAD_W       = 16;
    localparam int INTERVAL_W      = 16;
    localparam int COUNT_OUT_W     = 5;
    localparam int ENTRY_W         = ID_W + PAYLOAD_W;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd8;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_TICK    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] payload;
        logic                 imm;
    } cmd_t;

endpackage

// ===== hw/rtl/paced_dedup_event_queue.sv =====
// ============================================================================
// paced_dedup_event_queue
// Paced event queue with duplicate filter: releases at most one event per
// interval of ticks.
// ============================================================================
//  channel   handshake          payload
//  command   start / busy       operation, item_id, item_payload,
//                               immediate_allowed
//  result    done (1 cycle)     released, released_id, released_payload,
//                               duplicate_dropped, overflow_dropped,
//                               queued_count
//  config    cfg_wr_en          cfg_wr_data (release_interval)
//
//  A command passes the command queue and result registers to its result;
//  an enqueue into a non-empty queue scans the waiting entries one per cycle
//  through the store's read port; a releasing tick passes through S_POP.
//  The command queue holds two beats; busy is high while it is full.
//  No clearing pass after reset: read data is used only from occupied slots.
//  Results are strobed on done and cannot be held off.
// ============================================================================
module paced_dedup_event_queue #(
    parameter int QUEUE_DEPTH = pdeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pdeq_pkg::OP_W-1:0]           operation,
    input  logic [pdeq_pkg::ID_W-1:0]           item_id,
    input  logic [pdeq_pkg::PAYLOAD_W-1:0]      item_payload,
    input  logic                                immediate_allowed,
    input  logic                                cfg_wr_en,
    input  logic [pdeq_pkg::INTERVAL_W-1:0]     cfg_wr_data,
    output logic                                done,
    output logic                                released,
    output logic [pdeq_pkg::ID_W-1:0]           released_id,
    output logic [pdeq_pkg::PAYLOAD_W-1:0]      released_payload,
    output logic                                duplicate_dropped,
    output logic                                overflow_dropped,
    output logic [pdeq_pkg::COUNT_OUT_W-1:0]    queued_count
);

    logic           cmd_valid;
    pdeq_pkg::cmd_t cmd;
    logic           cmd_pop;

    pdeq_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .item_id           (item_id),
        .item_payload      (item_payload),
        .immediate_allowed (immediate_allowed),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd),
        .cmd_pop           (cmd_pop)
    );

    pdeq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .cmd_valid         (cmd_valid),
        .cmd               (cmd),
        .cmd_pop           (cmd_pop),
        .done              (done),
        .released          (released),
        .released_id       (released_id),
        .released_payload  (released_payload),
        .duplicate_dropped (duplicate_dropped),
        .overflow_dropped  (overflow_dropped),
        .queued_count      (queued_count)
    );

endmodule

// ===== hw/rtl/pdeq_ram.sv =====
// ============================================================================
// pdeq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module pdeq_ram #(
    parameter int WIDTH = pdeq_pkg::ENTRY_W,
    parameter int DEPTH = pdeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/pdeq_front.sv =====
// ============================================================================
// pdeq_front
// Command intake: decode the operation and hold commands in a two-beat queue.
// ============================================================================
module pdeq_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pdeq_pkg::OP_W-1:0]          operation,
    input  logic [pdeq_pkg::ID_W-1:0]          item_id,
    input  logic [pdeq_pkg::PAYLOAD_W-1:0]     item_payload,
    input  logic                               immediate_allowed,
    output logic                               cmd_valid,
    output pdeq_pkg::cmd_t                     cmd,
    input  logic                               cmd_pop
);

    pdeq_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push;
    pdeq_pkg::cmd_t cmd_in;

    assign busy      = (fill_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.op      = pdeq_pkg::op_t'(operation);
        cmd_in.id      = item_id;
        cmd_in.payload = item_payload;
        cmd_in.imm     = immediate_allowed;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (cmd_pop && cmd_valid)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        unique case ({push, cmd_pop && cmd_valid})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== hw/rtl/pdeq_back.sv =====
// ============================================================================
// pdeq_back
// Execution engine: pacing timer, FIFO storage, serial duplicate scan, result.
// ============================================================================
module pdeq_back #(
    parameter int QUEUE_DEPTH = pdeq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pdeq_pkg::INTERVAL_W-1:0]     cfg_wr_data,
    input  logic                                cmd_valid,
    input  pdeq_pkg::cmd_t                      cmd,
    output logic                                cmd_pop,
    output logic                                done,
    output logic                                released,
    output logic [pdeq_pkg::ID_W-1:0]           released_id,
    output logic [pdeq_pkg::PAYLOAD_W-1:0]      released_payload,
    output logic                                duplicate_dropped,
    output logic                                overflow_dropped,
    output logic [pdeq_pkg::COUNT_OUT_W-1:0]    queued_count
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = IW + 1;
    localparam int IDW = pdeq_pkg::ID_W;
    localparam int PW  = pdeq_pkg::PAYLOAD_W;
    localparam int TW  = pdeq_pkg::INTERVAL_W;
    localparam int EW  = pdeq_pkg::ENTRY_W;
    localparam int QW  = pdeq_pkg::COUNT_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POP
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   scan_reg, scan_next;
    logic [TW-1:0]   ticks_reg, ticks_next;
    logic [TW-1:0]   interval_reg, interval_next;
    logic [IDW-1:0]  id_reg, id_next;
    logic [PW-1:0]   payload_reg, payload_next;
    logic            done_reg, done_next;
    logic            released_reg, released_next;
    logic [IDW-1:0]  rel_id_reg, rel_id_next;
    logic [PW-1:0]   rel_payload_reg, rel_payload_next;
    logic            dup_reg, dup_next;
    logic            ovf_reg, ovf_next;
    logic [QW-1:0]   qcount_reg, qcount_next;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic [IW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;
    logic [IDW-1:0]  rd_id;
    logic [PW-1:0]   rd_payload;
    logic [TW-1:0]   ticks_inc;
    logic            passed;
    logic            passed_inc;
    logic [CW-1:0]   scan_inc;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH))
        begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    pdeq_ram #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_id      = ram_rdata[EW-1 -: IDW];
    assign rd_payload = ram_rdata[PW-1:0];
    assign ticks_inc  = (ticks_reg == {TW{1'b1}}) ? ticks_reg : ticks_reg + 1'b1;
    assign passed     = (ticks_reg >= interval_reg);
    assign passed_inc = (ticks_inc >= interval_reg);
    assign scan_inc   = scan_reg + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        scan_next        = scan_reg;
        ticks_next       = ticks_reg;
        interval_next    = cfg_wr_en ? cfg_wr_data : interval_reg;
        id_next          = id_reg;
        payload_next     = payload_reg;
        done_next        = 1'b0;
        released_next    = 1'b0;
        rel_id_next      = '0;
        rel_payload_next = '0;
        dup_next         = 1'b0;
        ovf_next         = 1'b0;
        cmd_pop          = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = slot_of(head_reg, count_reg);
        ram_wdata        = {id_reg, payload_reg};
        ram_raddr        = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    id_next      = cmd.id;
                    payload_next = cmd.payload;
                    unique case (cmd.op)
                        pdeq_pkg::OP_ENQUEUE:
                        begin
                            if (cmd.imm && passed && (count_reg == '0))
                            begin
                                done_next        = 1'b1;
                                released_next    = 1'b1;
                                rel_id_next      = cmd.id;
                                rel_payload_next = cmd.payload;
                                ticks_next       = '0;
                            end
                            else if (count_reg == '0)
                            begin
                                // empty queue: no duplicate possible, append
                                ram_we     = 1'b1;
                                ram_wdata  = {cmd.id, cmd.payload};
                                count_next = count_reg + 1'b1;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        pdeq_pkg::OP_TICK:
                        begin
                            ticks_next = ticks_inc;
                            if (passed_inc && (count_reg != '0))
                            begin
                                state_next = S_POP;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        pdeq_pkg::OP_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                            ticks_next = '0;
                            done_next  = 1'b1;
                        end
                        pdeq_pkg::OP_NONE:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                ram_raddr = slot_of(head_reg, scan_inc);
                if (rd_id == id_reg)
                begin
                    dup_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (scan_inc == count_reg)
                begin
                    if (count_reg == CW'(QUEUE_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_inc;
                end
            end
            S_POP:
            begin
                done_next        = 1'b1;
                released_next    = 1'b1;
                rel_id_next      = rd_id;
                rel_payload_next = rd_payload;
                head_next        = slot_of(head_reg, CW'(1));
                count_next       = count_reg - 1'b1;
                ticks_next       = '0;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        qcount_next = QW'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            scan_reg        <= '0;
            ticks_reg       <= '0;
            interval_reg    <= pdeq_pkg::INTERVAL_RESET;
            id_reg          <= '0;
            payload_reg     <= '0;
            done_reg        <= 1'b0;
            released_reg    <= 1'b0;
            rel_id_reg      <= '0;
            rel_payload_reg <= '0;
            dup_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            qcount_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            scan_reg        <= scan_next;
            ticks_reg       <= ticks_next;
            interval_reg    <= interval_next;
            id_reg          <= id_next;
            payload_reg     <= payload_next;
            done_reg        <= done_next;
            released_reg    <= released_next;
            rel_id_reg      <= rel_id_next;
            rel_payload_reg <= rel_payload_next;
            dup_reg         <= dup_next;
            ovf_reg         <= ovf_next;
            qcount_reg      <= qcount_next;
        end
    end

    assign done              = done_reg;
    assign released          = released_reg;
    assign released_id       = rel_id_reg;
    assign released_payload  = rel_payload_reg;
    assign duplicate_dropped = dup_reg;
    assign overflow_dropped  = ovf_reg;
    assign queued_count      = qcount_reg;

endmodule

// ===== dv/paced_dedup_event_queue_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// paced_dedup_event_queue_tb
// Self-checking bench for the paced duplicate-filtering event queue. A short
// table of commands covers the field extremes, every operation, duplicates,
// immediate release and the interval extremes. Randomized phases follow, each
// under its own release interval, with fill bursts that force overflow and
// duplicate-while-full. Results are compared field by field against the table
// (typed rows) or an in-bench predictor of the queue, ticks and pacing rule.
// ============================================================================
module paced_dedup_event_queue_tb;
    import pdeq_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int SLOT_W       = $clog2(DEPTH);
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_BEATS  = 125;
    localparam int PHASES       = 8;
    localparam int SETTLE_CYC   = DEPTH + 4;

    typedef struct packed {
        logic                   rel;
        logic [ID_W-1:0]        id;
        logic [PAYLOAD_W-1:0]   pay;
        logic                   dup;
        logic                   ovf;
        logic [COUNT_OUT_W-1:0] cnt;
    } outcome_t;

    typedef struct packed {
        logic                   cfg_wr;
        logic [INTERVAL_W-1:0]  cfg_val;
        op_t                    op;
        logic [ID_W-1:0]        id;
        logic [PAYLOAD_W-1:0]   pay;
        logic                   imm;
        logic                   typed;
        outcome_t               want;
    } stim_row_t;

    localparam outcome_t NO_OUTCOME = '0;

    logic                   clk;
    logic                   rst_n             = 1'b0;
    logic                   start             = 1'b0;
    logic                   busy;
    logic [OP_W-1:0]        operation         = '0;
    logic [ID_W-1:0]        item_id           = '0;
    logic [PAYLOAD_W-1:0]   item_payload      = '0;
    logic                   immediate_allowed = 1'b0;
    logic                   cfg_wr_en         = 1'b0;
    logic [INTERVAL_W-1:0]  cfg_wr_data       = '0;
    logic                   done;
    logic                   released;
    logic [ID_W-1:0]        released_id;
    logic [PAYLOAD_W-1:0]   released_payload;
    logic                   duplicate_dropped;
    logic                   overflow_dropped;
    logic [COUNT_OUT_W-1:0] queued_count;

    paced_dedup_event_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .operation         (operation),
        .item_id           (item_id),
        .item_payload      (item_payload),
        .immediate_allowed (immediate_allowed),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .done              (done),
        .released          (released),
        .released_id       (released_id),
        .released_payload  (released_payload),
        .duplicate_dropped (duplicate_dropped),
        .overflow_dropped  (overflow_dropped),
        .queued_count      (queued_count)
    );

    logic [ID_W-1:0]        held_id [DEPTH];
    logic [PAYLOAD_W-1:0]   held_pay [DEPTH];
    logic [SLOT_W-1:0]      head_slot      = '0;
    int unsigned            held_cnt       = 0;
    logic [INTERVAL_W-1:0]  since_release  = '0;
    logic [INTERVAL_W-1:0]  pace_interval  = INTERVAL_RESET;

    outcome_t               due_outcomes[$];
    int                     fail_cnt       = 0;
    int                     quiet_cycles   = 0;
    int                     gap_max        = 17;
    int unsigned            fixed_iv[PHASES] = '{1, 0, 2, 4, 3, 65535, 7, 5};

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic pace_and_filter(input op_t op, input logic [ID_W-1:0] id,
                                   input logic [PAYLOAD_W-1:0] pay, input logic imm,
                                   output outcome_t r);
        logic              hit;
        logic [SLOT_W-1:0] slot;
        r   = '0;
        hit = 1'b0;
        case (op)
            OP_ENQUEUE:
            begin
                if (imm && since_release >= pace_interval && held_cnt == 0)
                begin
                    r.rel         = 1'b1;
                    r.id          = id;
                    r.pay         = pay;
                    since_release = '0;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        slot = head_slot + SLOT_W'(i);
                        if (i < held_cnt && held_id[slot] == id)
                            hit = 1'b1;
                    end
                    r.dup = hit;
                    if (!hit)
                    begin
                        if (held_cnt >= DEPTH)
                            r.ovf = 1'b1;
                        else
                        begin
                            slot           = head_slot + SLOT_W'(held_cnt);
                            held_id[slot]  = id;
                            held_pay[slot] = pay;
                            held_cnt++;
                        end
                    end
                end
            end
            OP_TICK:
            begin
                if (since_release != '1)
                    since_release++;
                if (since_release >= pace_interval && held_cnt > 0)
                begin
                    r.rel         = 1'b1;
                    r.id          = held_id[head_slot];
                    r.pay         = held_pay[head_slot];
                    head_slot++;
                    held_cnt--;
                    since_release = '0;
                end
            end
            OP_CLEAR:
            begin
                head_slot     = '0;
                held_cnt      = 0;
                since_release = '0;
            end
            default: ;
        endcase
        r.cnt = COUNT_OUT_W'(held_cnt);
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            if (due_outcomes.size() == 0)
            begin
                $display("%0t: result with none expected, expected nothing actual id %0h",
                         $time, released_id);
                fail_cnt++;
            end
            else
            begin
                e = due_outcomes.pop_front();
                check_field("released", e.rel, released);
                check_field("released_id", e.id, released_id);
                check_field("released_payload", e.pay, released_payload);
                check_field("duplicate_dropped", e.dup, duplicate_dropped);
                check_field("overflow_dropped", e.ovf, overflow_dropped);
                check_field("queued_count", e.cnt, queued_count);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic issue_beat(input op_t op, input logic [ID_W-1:0] id,
                              input logic [PAYLOAD_W-1:0] pay, input logic imm,
                              input logic typed, input outcome_t want);
        outcome_t predicted;
        int       gap;
        gap = $urandom_range(gap_max, 0);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start             <= 1'b1;
        operation         <= op;
        item_id           <= id;
        item_payload      <= pay;
        immediate_allowed <= imm;
        do
            @(posedge clk);
        while (busy);
        pace_and_filter(op, id, pay, imm, predicted);
        due_outcomes.push_back(typed ? want : predicted);
    endtask

    // hold start low and let every outstanding beat come back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (due_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_interval(input logic [INTERVAL_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        pace_interval = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random_phase(input int beats);
        int  sent;
        int  pick;
        int  base;
        int  burst;
        op_t kind;
        logic [ID_W-1:0] id;
        sent = 0;
        while (sent < beats)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 8)
            begin
                // fill to depth or past it, then repeat an id from the burst
                base  = $urandom_range(4095 - 20, 0);
                burst = $urandom_range(18, 16);
                for (int k = 0; k < burst; k++)
                    issue_beat(OP_ENQUEUE, ID_W'(base + k), PAYLOAD_W'($urandom),
                               1'($urandom), 1'b0, NO_OUTCOME);
                issue_beat(OP_ENQUEUE, ID_W'(base + $urandom_range(burst - 1, 0)),
                           PAYLOAD_W'($urandom), 1'b0, 1'b0, NO_OUTCOME);
                sent += burst + 1;
            end
            else
            begin
                if (pick < 45)
                    kind = OP_ENQUEUE;
                else if (pick < 92)
                    kind = OP_TICK;
                else if (pick < 96)
                    kind = OP_CLEAR;
                else
                    kind = OP_NONE;
                id = $urandom_range(1, 0) ? ID_W'($urandom_range(15, 0)) : ID_W'($urandom);
                issue_beat(kind, id, PAYLOAD_W'($urandom), 1'($urandom), 1'b0, NO_OUTCOME);
                sent++;
            end
        end
    endtask

    function automatic stim_row_t mk_row(input logic wr, input logic [INTERVAL_W-1:0] cv,
                                         input op_t op, input logic [ID_W-1:0] id,
                                         input logic [PAYLOAD_W-1:0] pay, input logic imm,
                                         input logic typed, input outcome_t want);
        stim_row_t row;
        row.cfg_wr  = wr;
        row.cfg_val = cv;
        row.op      = op;
        row.id      = id;
        row.pay     = pay;
        row.imm     = imm;
        row.typed   = typed;
        row.want    = want;
        return row;
    endfunction

    initial
    begin
        stim_row_t rows[24];
        logic [INTERVAL_W-1:0] iv;

        rows[0]  = mk_row(0, 0, OP_NONE, 12'hFFF, 16'hFFFF, 1, 1, NO_OUTCOME);
        rows[1]  = mk_row(0, 0, OP_TICK, 12'h000, 16'h0000, 0, 1, NO_OUTCOME);
        rows[2]  = mk_row(0, 0, OP_ENQUEUE, 12'hFFF, 16'hFFFF, 1, 1,
                          outcome_t'{1'b0, 12'h000, 16'h0000, 1'b0, 1'b0, 5'd1});
        rows[3]  = mk_row(0, 0, OP_ENQUEUE, 12'hFFF, 16'h0000, 0, 1,
                          outcome_t'{1'b0, 12'h000, 16'h0000, 1'b1, 1'b0, 5'd1});
        rows[4]  = mk_row(0, 0, OP_ENQUEUE, 12'h000, 16'h0000, 1, 1,
                          outcome_t'{1'b0, 12'h000, 16'h0000, 1'b0, 1'b0, 5'd2});
        rows[5]  = mk_row(0, 0, OP_ENQUEUE, 12'h000, 16'hFFFF, 0, 1,
                          outcome_t'{1'b0, 12'h000, 16'h0000, 1'b1, 1'b0, 5'd2});
        for (int i = 6; i < 13; i++)
            rows[i] = mk_row(0, 0, OP_TICK, 12'h000, 16'h0000, 0, 0, NO_OUTCOME);
        rows[13] = mk_row(0, 0, OP_CLEAR, 12'hFFF, 16'hFFFF, 1, 1, NO_OUTCOME);
        rows[14] = mk_row(0, 0, OP_ENQUEUE, 12'h800, 16'h8000, 1, 0, NO_OUTCOME);
        rows[15] = mk_row(1, 16'h0000, OP_TICK, 12'h000, 16'h0000, 0, 0, NO_OUTCOME);
        rows[16] = mk_row(0, 0, OP_ENQUEUE, 12'h555, 16'h5555, 1, 1,
                          outcome_t'{1'b1, 12'h555, 16'h5555, 1'b0, 1'b0, 5'd0});
        rows[17] = mk_row(0, 0, OP_ENQUEUE, 12'hAAA, 16'hAAAA, 0, 0, NO_OUTCOME);
        rows[18] = mk_row(0, 0, OP_ENQUEUE, 12'h123, 16'h4567, 1, 0, NO_OUTCOME);
        rows[19] = mk_row(0, 0, OP_TICK, 12'h000, 16'h0000, 0, 0, NO_OUTCOME);
        rows[20] = mk_row(1, 16'hFFFF, OP_TICK, 12'h000, 16'h0000, 0, 0, NO_OUTCOME);
        rows[21] = mk_row(0, 0, OP_NONE, 12'h3C3, 16'h3C3C, 0, 0, NO_OUTCOME);
        rows[22] = mk_row(0, 0, OP_CLEAR, 12'h000, 16'h0000, 0, 1, NO_OUTCOME);
        rows[23] = mk_row(1, INTERVAL_RESET, OP_ENQUEUE, 12'h7FF, 16'h7FFF, 1, 0, NO_OUTCOME);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].cfg_wr)
            begin
                drain();
                set_interval(rows[i].cfg_val);
            end
            issue_beat(rows[i].op, rows[i].id, rows[i].pay, rows[i].imm,
                       rows[i].typed, rows[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            iv = (ph == 3 || ph == 6) ? INTERVAL_W'($urandom_range(12, 0))
                                      : INTERVAL_W'(fixed_iv[ph]);
            set_interval(iv);
            gap_max = (ph % 3 == 1) ? 0 : 17;
            run_random_phase(PHASE_BEATS);
        end

        drain();
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
